/* hdl/hwrm_pkg.sv */
package hwrm_pkg;

	// Field widths of the sample and result transactions.
	localparam int unsigned CountW  = 16;
	localparam int unsigned ExpoW   = 24;
	localparam int unsigned RadW    = 32;

	// Internal arithmetic widths.
	localparam int unsigned WeightW = 17;   // Q1.16, up to 1.0
	localparam int unsigned ProdW   = 49;   // weight times Q16.16 radiance
	localparam int unsigned SumW    = 52;   // Q20.32 weighted radiance sum
	localparam int unsigned WsumW   = 21;   // Q5.16 weight sum

	// Shared divider: left-aligned numerator, two quotient bits per step.
	localparam int unsigned DivNumW    = 52;
	localparam int unsigned DivDenW    = 24;
	localparam int unsigned DivStepW   = 5;
	localparam int unsigned DivSteps32 = 16;  // 32-bit quotient
	localparam int unsigned DivSteps52 = 26;  // 52-bit quotient

	// Serial multiplier: one multiplier bit per step.
	localparam int unsigned MulSteps = WeightW;
	localparam int unsigned MulCntW  = 5;

	// Configuration port.
	localparam int unsigned PaddrW = 3;
	localparam int unsigned PdataW = 32;
	localparam logic RegMinCount = 1'b0;
	localparam logic RegMaxCount = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WDIV,
		ST_RDIV,
		ST_MUL,
		ST_ACCUM,
		ST_QDIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                start;
		logic [DivStepW-1:0] steps;
	} div_req_t;

endpackage

/* hdl/hwrm_sample_if.sv */
interface hwrm_sample_if import hwrm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CountW-1:0] raw_count;
	logic [CountW-1:0] dark_count;
	logic [ExpoW-1:0]  exposure_us;
	logic              last_bracket;

	modport source (
		output valid, raw_count, dark_count, exposure_us, last_bracket,
		input  ready
	);
	modport sink (
		input  valid, raw_count, dark_count, exposure_us, last_bracket,
		output ready
	);
endinterface

/* hdl/hwrm_result_if.sv */
interface hwrm_result_if import hwrm_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [RadW-1:0] radiance;
	logic            no_weight;

	modport source (
		output valid, radiance, no_weight,
		input  ready
	);
	modport sink (
		input  valid, radiance, no_weight,
		output ready
	);
endinterface

/* hdl/hdr_weighted_radiance_merge_core.sv */
// Channel   | Dir | Payload                                            | Transaction when
// ----------+-----+----------------------------------------------------+------------------------
// sample    | in  | raw_count, dark_count, exposure_us, last_bracket   | valid && ready
// result    | out | radiance, no_weight                                | valid && ready
// APB cfg   | in  | paddr, pwdata (min_count at 0, max_count at 4)     | psel && penable && pwrite
//
// Flow: a bracket whose weight is computed takes two radix-4 divisions on the shared
// divider (weight, then count over exposure) and a serial multiply, plus setup and
// accumulate; a zero-weight bracket only passes through setup and accumulate.
// The last bracket of a pixel adds a division of the sums (if nonzero) and an emit step.
// Reset: arst_n clears the controller, accumulators and output valid; limits go to defaults.
// Stalls: a finished result waits in the output register while the next transaction is
// taken; only a second result waits for that register to drain.
module hdr_weighted_radiance_merge_core import hwrm_pkg::*; #(
	parameter int unsigned MAX_BRACKETS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	hwrm_sample_if.sink       sample,
	hwrm_result_if.source     result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [PaddrW-1:0] paddr,
	input  logic [PdataW-1:0] pwdata,
	output logic [PdataW-1:0] prdata,
	output logic              pready
);

	localparam int unsigned CntW = $clog2(MAX_BRACKETS + 1);

	// Configuration registers.
	logic [CountW-1:0] min_q;
	logic [CountW-1:0] max_q;

	// Current bracket.
	logic [CountW-1:0] c_q;
	logic [ExpoW-1:0]  expo_q;
	logic              last_q;
	logic              active_q;
	logic [WeightW-1:0] w_q;

	// Pixel accumulators.
	logic [SumW-1:0]  sum_q;
	logic [WsumW-1:0] wsum_q;
	logic [CntW-1:0]  cnt_q;

	// Output register.
	logic              out_valid_q;
	logic [RadW-1:0]   out_rad_q;
	logic              out_nw_q;

	state_t state_q;
	state_t state_d;

	// Shared divider and the multiplier.
	div_req_t           div_req;
	logic [DivNumW-1:0] div_numer;
	logic [DivDenW-1:0] div_denom;
	logic               div_done;
	logic [DivNumW-1:0] div_quot;
	logic               mul_start;
	logic               mul_done;
	logic [ProdW-1:0]   mul_prod;

	// Weight geometry of the current bracket.
	logic              outside;
	logic [CountW-1:0] span;
	logic [CountW:0]   twice;
	logic [CountW:0]   mid2;
	logic [CountW:0]   offs;
	logic              wzero;
	logic [CountW-1:0] wnum;

	logic              accept;
	logic              cfg_write;
	logic              out_free;
	logic [CountW-1:0] c_in;
	logic [RadW-1:0]   q_sat;

	assign accept    = sample.valid && sample.ready;
	assign cfg_write = psel && penable && pwrite && pready;
	assign out_free  = !out_valid_q || result.ready;
	assign c_in      = (sample.raw_count > sample.dark_count) ?
	                   sample.raw_count - sample.dark_count : '0;

	// The weight is zero outside the open interval (min, max); inside it falls
	// linearly from 1.0 at the midpoint, so the divider only sees (span - offs) / span.
	always_comb begin
		outside = (c_q <= min_q) || (c_q >= max_q);
		span    = max_q - min_q;
		twice   = {c_q, 1'b0};
		mid2    = {1'b0, min_q} + {1'b0, max_q};
		offs    = (twice > mid2) ? twice - mid2 : mid2 - twice;
		wzero   = outside || (offs >= {1'b0, span});
		wnum    = span - offs[CountW-1:0];
	end

	// The quotient of the final division saturates at the top of Q16.16.
	assign q_sat = (div_quot[DivNumW-1:RadW] != '0) ? '1 : div_quot[RadW-1:0];

	// Configuration port: the register is picked by the word address bit alone.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegMaxCount) ?
	                {{(PdataW-CountW){1'b0}}, max_q} : {{(PdataW-CountW){1'b0}}, min_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '1;
		end else if (cfg_write) begin
			if (paddr[2] == RegMinCount) begin
				min_q <= pwdata[CountW-1:0];
			end else begin
				max_q <= pwdata[CountW-1:0];
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample.valid) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				// Brackets beyond the limit and zero-weight brackets add nothing.
				if (!active_q || wzero) begin
					state_d = ST_ACCUM;
				end else begin
					state_d = ST_WDIV;
				end
			end
			ST_WDIV: begin
				if (div_done) begin
					state_d = ST_RDIV;
				end
			end
			ST_RDIV: begin
				if (div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_done) begin
					state_d = ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				priority if (!last_q) begin
					state_d = ST_IDLE;
				end else if (wsum_q == '0) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_QDIV;
				end
			end
			ST_QDIV: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Controller outputs: the divider and multiplier are started in the cycle
	// that hands their operands over.
	always_comb begin
		sample.ready = 1'b0;
		div_req      = '0;
		div_numer    = '0;
		div_denom    = '0;
		mul_start    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample.ready = 1'b1;
			end
			ST_SETUP: begin
				div_req.start = active_q && !wzero;
				div_req.steps = DivStepW'(DivSteps32);
				div_numer     = {wnum, {(DivNumW-CountW){1'b0}}};
				div_denom     = {{(DivDenW-CountW){1'b0}}, span};
			end
			ST_WDIV: begin
				// Bracket radiance: corrected count in Q16.16 over the exposure.
				div_req.start = div_done;
				div_req.steps = DivStepW'(DivSteps32);
				div_numer     = {c_q, {(DivNumW-CountW){1'b0}}};
				div_denom     = expo_q;
			end
			ST_RDIV: begin
				mul_start = div_done;
			end
			ST_ACCUM: begin
				div_req.start = last_q && (wsum_q != '0);
				div_req.steps = DivStepW'(DivSteps52);
				div_numer     = sum_q;
				div_denom     = {{(DivDenW-WsumW){1'b0}}, wsum_q};
			end
			ST_MUL, ST_QDIV, ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			wsum_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL && mul_done) begin
				sum_q  <= sum_q + {{(SumW-ProdW){1'b0}}, mul_prod};
				wsum_q <= wsum_q + {{(WsumW-WeightW){1'b0}}, w_q};
			end
			if (state_q == ST_ACCUM && active_q) begin
				cnt_q <= cnt_q + CntW'(1);
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
				sum_q       <= '0;
				wsum_q      <= '0;
				cnt_q       <= '0;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_q      <= c_in;
			expo_q   <= (sample.exposure_us == '0) ? ExpoW'(1) : sample.exposure_us;
			last_q   <= sample.last_bracket;
			active_q <= cnt_q < CntW'(MAX_BRACKETS);
		end
		if (state_q == ST_WDIV && div_done) begin
			w_q <= div_quot[WeightW-1:0];
		end
		// A pixel whose weight sum is zero reports zero radiance with the flag set.
		if (state_q == ST_EMIT && out_free) begin
			out_rad_q <= (wsum_q == '0) ? '0 : q_sat;
			out_nw_q  <= (wsum_q == '0);
		end
	end

	// The result is loaded into the output register in the emit step, once the
	// previous result has left it, and stays unchanged while it waits.
	assign result.valid     = out_valid_q;
	assign result.radiance  = out_rad_q;
	assign result.no_weight = out_nw_q;

	hwrm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.numer  (div_numer),
		.denom  (div_denom),
		.done   (div_done),
		.quot   (div_quot)
	);

	hwrm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (div_quot[RadW-1:0]),
		.mplier (w_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

endmodule

/* hdl/hwrm_div.sv */
// Restoring divider, radix 4. The numerator is left-aligned and shifted out
// two bits per cycle; the quotient is shifted in from the right.
module hwrm_div import hwrm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  div_req_t           req,
	input  logic [DivNumW-1:0] numer,
	input  logic [DivDenW-1:0] denom,
	output logic               done,
	output logic [DivNumW-1:0] quot
);

	logic [DivNumW-1:0]  num_q;
	logic [DivNumW-1:0]  quot_q;
	logic [DivDenW-1:0]  rem_q;
	logic [DivDenW-1:0]  den_q;
	logic [DivStepW-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [DivDenW:0]    part1;
	logic [DivDenW:0]    part2;
	logic [DivDenW:0]    diff1;
	logic [DivDenW:0]    diff2;
	logic                qbit1;
	logic                qbit2;
	logic [DivDenW-1:0]  rem1;
	logic [DivDenW-1:0]  rem2;

	always_comb begin
		part1 = {rem_q, num_q[DivNumW-1]};
		qbit1 = part1 >= {1'b0, den_q};
		diff1 = part1 - {1'b0, den_q};
		rem1  = qbit1 ? diff1[DivDenW-1:0] : part1[DivDenW-1:0];
		part2 = {rem1, num_q[DivNumW-2]};
		qbit2 = part2 >= {1'b0, den_q};
		diff2 = part2 - {1'b0, den_q};
		rem2  = qbit2 ? diff2[DivDenW-1:0] : part2[DivDenW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DivStepW'(1);
				if (cnt_q == DivStepW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= numer;
			den_q  <= denom;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[DivNumW-3:0], 2'b00};
			rem_q  <= rem2;
			quot_q <= {quot_q[DivNumW-3:0], qbit1, qbit2};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* hdl/hwrm_mul.sv */
// Shift-and-add multiplier, one multiplier bit per cycle.
module hwrm_mul import hwrm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [RadW-1:0]    mcand,
	input  logic [WeightW-1:0] mplier,
	output logic               done,
	output logic [ProdW-1:0]   prod
);

	logic [ProdW-1:0]   mc_q;
	logic [WeightW-1:0] mp_q;
	logic [ProdW-1:0]   acc_q;
	logic [MulCntW-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MulCntW'(MulSteps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - MulCntW'(1);
				if (cnt_q == MulCntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mc_q  <= {{(ProdW-RadW){1'b0}}, mcand};
			mp_q  <= mplier;
			acc_q <= '0;
		end else if (busy_q) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= {mc_q[ProdW-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[WeightW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

// Self-checking bench for the HDR radiance merge core. Brackets are pushed through the
// sample channel, an in-bench merge predictor works out the radiance of every finished
// pixel, and each result transaction is compared against the oldest pending prediction.
module tb import hwrm_pkg::*;;

	// Must match the parameter of the instance below.
	localparam int unsigned BRACKET_LIMIT = 8;
	// Room for a weighted bracket and the final division of the sums, so this comfortably
	// covers any work still in flight once the last result is out.
	localparam int unsigned DRAIN_CYCLES  = 150;
	// Cycles without any transaction before the run is declared hung.
	localparam int unsigned STALL_LIMIT   = 5000;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned PHASE_ITEMS   = 200;

	localparam logic [PaddrW-1:0] ADDR_MIN = {RegMinCount, 2'b00};
	localparam logic [PaddrW-1:0] ADDR_MAX = {RegMaxCount, 2'b00};

	typedef struct packed {
		logic [RadW-1:0] radiance;
		logic            no_weight;
	} pixel_result_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [PaddrW-1:0] paddr;
	logic [PdataW-1:0] pwdata;
	logic [PdataW-1:0] prdata;
	logic              pready;

	hwrm_sample_if sample_ch ();
	hwrm_result_if result_ch ();

	hdr_weighted_radiance_merge_core #(
		.MAX_BRACKETS(BRACKET_LIMIT)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// Predictor copy of the limit registers and of the per-pixel accumulators.
	logic [CountW-1:0] lim_min = '0;
	logic [CountW-1:0] lim_max = '1;
	logic [SumW-1:0]   acc_weighted = '0;
	logic [WsumW-1:0]  acc_weight = '0;
	int unsigned       acc_brackets = 0;

	// Radiance of every finished pixel whose result transaction has not been seen yet.
	pixel_result_t pending_pixels[$];

	int unsigned fail_count = 0;
	int unsigned sent_items = 0;
	int unsigned idle_cycles = 0;
	bit          tx_gaps_on = 1'b1;
	bit          rx_stalls_on = 1'b1;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Triangular weight in Q1.16: zero at or outside the limits, 1.0 midway between them.
	function automatic logic [WeightW-1:0] tri_weight(logic [CountW-1:0] c);
		int unsigned span;
		int unsigned twice;
		int unsigned mid2;
		int unsigned offs;
		if (c <= lim_min || c >= lim_max) begin
			return '0;
		end
		span  = 32'(lim_max) - 32'(lim_min);
		twice = 2 * 32'(c);
		mid2  = 32'(lim_min) + 32'(lim_max);
		offs  = (twice > mid2) ? twice - mid2 : mid2 - twice;
		if (offs >= span) begin
			return '0;
		end
		return WeightW'((64'(span - offs) << 16) / 64'(span));
	endfunction

	// Folds one accepted bracket into the accumulators. The last bracket of a pixel
	// closes it: the weighted mean is queued as the expected result and the sums clear.
	function automatic void merge_bracket(logic [CountW-1:0] raw, logic [CountW-1:0] dark,
			logic [ExpoW-1:0] expo, logic last);
		logic [CountW-1:0] c;
		logic [63:0]       divisor;
		logic [63:0]       w;
		logic [63:0]       r;
		logic [63:0]       q;
		pixel_result_t     res;
		c = (raw > dark) ? raw - dark : '0;
		divisor = (expo == '0) ? 64'd1 : 64'(expo);
		// Brackets beyond the limit are dropped, but their last flag still counts.
		if (acc_brackets < BRACKET_LIMIT) begin
			w = 64'(tri_weight(c));
			r = (64'(c) << 16) / divisor;
			acc_weighted = SumW'(64'(acc_weighted) + w * r);
			acc_weight = WsumW'(64'(acc_weight) + w);
			acc_brackets++;
		end
		if (last) begin
			if (acc_weight == '0) begin
				res.radiance = '0;
				res.no_weight = 1'b1;
			end else begin
				q = 64'(acc_weighted) / 64'(acc_weight);
				res.radiance = (q > 64'hFFFF_FFFF) ? '1 : RadW'(q);
				res.no_weight = 1'b0;
			end
			pending_pixels = {pending_pixels, res};
			acc_weighted = '0;
			acc_weight = '0;
			acc_brackets = 0;
		end
	endfunction

	// Mostly back-to-back, sometimes a few cycles, rarely a long gap.
	function automatic int unsigned pick_delay(bit enabled);
		int unsigned roll;
		if (!enabled) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 85) begin
			return $urandom_range(1, 3);
		end else if (roll < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Presents one bracket and waits for its transaction. Valid is left high so that a
	// following bracket can go back-to-back; whoever pauses the stream lowers it.
	task automatic send_bracket(input logic [CountW-1:0] raw, input logic [CountW-1:0] dark,
			input logic [ExpoW-1:0] expo, input logic last);
		int unsigned gap;
		gap = pick_delay(tx_gaps_on);
		if (gap > 0) begin
			@(negedge clk);
			sample_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sample_ch.valid = 1'b1;
		sample_ch.raw_count = raw;
		sample_ch.dark_count = dark;
		sample_ch.exposure_us = expo;
		sample_ch.last_bracket = last;
		do @(posedge clk); while (!sample_ch.ready);
		merge_bracket(raw, dark, expo, last);
		sent_items++;
	endtask

	// Stops the sample stream and lets the core run dry: every predicted result has come
	// back, and any bracket that produces no result has had time to finish as well.
	task automatic settle();
		@(negedge clk);
		sample_ch.valid = 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One APB transfer: setup cycle, then access cycle until pready. Reads are checked
	// against the predictor's copy of the register.
	task automatic reg_access(input logic wr, input logic [PaddrW-1:0] addr,
			input logic [CountW-1:0] value);
		logic [PdataW-1:0] want;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = addr;
		pwdata = PdataW'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		want = PdataW'((addr == ADDR_MIN) ? lim_min : lim_max);
		if (wr) begin
			if (addr == ADDR_MIN) begin
				lim_min = value;
			end else begin
				lim_max = value;
			end
		end else if (prdata !== want) begin
			fail_count++;
			$display("%0t: readback of register at %0d expected %h got %h",
				$time, addr, want, prdata);
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic program_limits(input logic [CountW-1:0] lo, input logic [CountW-1:0] hi);
		reg_access(1'b1, ADDR_MIN, lo);
		reg_access(1'b1, ADDR_MAX, hi);
		reg_access(1'b0, ADDR_MIN, '0);
		reg_access(1'b0, ADDR_MAX, '0);
	endtask

	// Reset limits span the whole count range: a mid-scale pixel, and a two-bracket pixel
	// mixing a useful bracket with a saturated one.
	task automatic test_reset_limits();
		reg_access(1'b0, ADDR_MIN, '0);
		reg_access(1'b0, ADDR_MAX, '0);
		send_bracket(16'd32768, 16'd0, 24'd1, 1'b1);
		send_bracket(16'd40000, 16'd1000, 24'd250, 1'b0);
		send_bracket(16'hFFFF, 16'd0, 24'd10, 1'b1);
	endtask

	// Field extremes: dark above raw, both at full scale, zero and full-scale exposure.
	task automatic test_field_corners();
		send_bracket(16'd100, 16'd200, 24'd5, 1'b1);
		send_bracket(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1);
		send_bracket(16'd1, 16'd0, 24'd0, 1'b1);
		send_bracket(16'hFFFE, 16'd0, 24'd0, 1'b0);
		send_bracket(16'hAAAA, 16'h5555, 24'hFFFFFF, 1'b1);
	endtask

	// A pixel with more brackets than the core keeps: the extra ones must not count,
	// and the final one still has to close the pixel.
	task automatic test_bracket_overflow();
		for (int i = 0; i < BRACKET_LIMIT + 2; i++) begin
			send_bracket(16'(1000 * (i + 1)), 16'd0, 24'(7 + i), 1'(i == BRACKET_LIMIT + 1));
		end
	endtask

	// Narrow, inverted and equal limits, plus a limit change in the middle of a pixel.
	task automatic test_limit_settings();
		settle();
		// With limits 0 and 2 a count of one sits exactly midway and gets full weight.
		program_limits(16'd0, 16'd2);
		send_bracket(16'd1, 16'd0, 24'd3, 1'b1);
		settle();
		program_limits(16'hFFFF, 16'd0);
		send_bracket(16'd30000, 16'd0, 24'd9, 1'b1);
		settle();
		program_limits(16'd1000, 16'd1000);
		send_bracket(16'd1000, 16'd0, 24'd9, 1'b1);
		settle();
		program_limits(16'd100, 16'd5000);
		send_bracket(16'd2000, 16'd10, 24'd40, 1'b0);
		settle();
		program_limits(16'd0, 16'hFFFF);
		send_bracket(16'd2000, 16'd10, 24'd80, 1'b1);
	endtask

	// The sender holds off until the core has returned every pending result.
	task automatic test_drain_pause();
		send_bracket(16'd5000, 16'd20, 24'd64, 1'b0);
		send_bracket(16'd9000, 16'd20, 24'd32, 1'b1);
		@(negedge clk);
		sample_ch.valid = 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		send_bracket(16'd12000, 16'd300, 24'd16, 1'b1);
	endtask

	// Pixels of random bracket count. Most counts are steered between the current limits
	// so that weights are nonzero; the rest are unconstrained noise.
	task automatic send_random_pixel();
		int unsigned       brackets;
		int unsigned       roll;
		logic [CountW-1:0] raw;
		logic [CountW-1:0] dark;
		logic [CountW-1:0] c;
		logic [ExpoW-1:0]  expo;
		brackets = ($urandom_range(0, 99) < 88) ? $urandom_range(1, BRACKET_LIMIT)
			: $urandom_range(BRACKET_LIMIT + 1, BRACKET_LIMIT + 4);
		for (int i = 0; i < brackets; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				dark = ($urandom_range(0, 3) == 0) ? CountW'($urandom)
					: CountW'($urandom_range(0, 300));
				c = (lim_min < lim_max) ? CountW'($urandom_range(lim_min, lim_max))
					: CountW'($urandom);
				if (32'(dark) + 32'(c) > 32'hFFFF) begin
					dark = '0;
				end
				raw = dark + c;
			end else begin
				raw = CountW'($urandom);
				dark = CountW'($urandom);
			end
			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				expo = ExpoW'($urandom_range(1, 4096));
			end else if (roll < 80) begin
				expo = ExpoW'($urandom);
			end else if (roll < 97) begin
				expo = ExpoW'($urandom_range(1, 16));
			end else begin
				expo = '0;
			end
			send_bracket(raw, dark, expo, 1'(i == brackets - 1));
		end
	endtask

	// Phases of random pixels, each under its own pair of limits. The first phases take
	// the extremes; later ones pick limits at random, the last in either order.
	task automatic test_random_pixels();
		logic [CountW-1:0] lo;
		logic [CountW-1:0] hi;
		int unsigned       start;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					lo = '0;
					hi = '1;
				end
				1: begin
					lo = 16'd0;
					hi = 16'd2;
				end
				2: begin
					lo = '1;
					hi = '0;
				end
				3: begin
					lo = 16'hFFFE;
					hi = 16'hFFFF;
				end
				RANDOM_PHASES - 1: begin
					lo = CountW'($urandom);
					hi = CountW'($urandom);
				end
				default: begin
					lo = CountW'($urandom_range(0, 40000));
					hi = CountW'($urandom_range(lo, 65535));
				end
			endcase
			settle();
			program_limits(lo, hi);
			start = sent_items;
			while (sent_items - start < PHASE_ITEMS) begin
				// Occasional pixels run with one or both sides never pausing.
				tx_gaps_on = ($urandom_range(0, 9) != 0);
				rx_stalls_on = ($urandom_range(0, 9) != 0);
				send_random_pixel();
			end
		end
	endtask

	// Result side: random stalls on ready, driven on the falling edge.
	initial begin : result_sink
		int unsigned stall;
		result_ch.ready = 1'b0;
		forever begin
			stall = pick_delay(rx_stalls_on);
			if (stall > 0) begin
				@(negedge clk);
				result_ch.ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			result_ch.ready = 1'b1;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	end

	// Every result transaction must match the oldest prediction, field by field.
	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_pixels.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result radiance %h no_weight %b",
					$time, result_ch.radiance, result_ch.no_weight);
			end else begin
				want = pending_pixels.pop_front();
				if (result_ch.radiance !== want.radiance) begin
					fail_count++;
					$display("%0t: radiance expected %h got %h",
						$time, want.radiance, result_ch.radiance);
				end
				if (result_ch.no_weight !== want.no_weight) begin
					fail_count++;
					$display("%0t: no_weight expected %b got %b",
						$time, want.no_weight, result_ch.no_weight);
				end
			end
		end
	end

	// Watchdog: any transaction on either channel or the register port counts as progress.
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.raw_count = '0;
		sample_ch.dark_count = '0;
		sample_ch.exposure_us = '0;
		sample_ch.last_bracket = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_reset_limits();
		test_field_corners();
		test_bracket_overflow();
		test_limit_settings();
		test_drain_pause();
		test_random_pixels();

		// Let the last pixel come back and give the core time to show anything extra.
		settle();
		if (fail_count == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
